@@ rtl/fta_pkg.sv @@
// Shared types and codes for the fan target lock arbiter.
// No dependencies; imported by the top level and by fta_cell.
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

  // request codes carried on in_kind
  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_LOCK   = 2'd1;
  localparam logic [1:0] KIND_UNLOCK = 2'd2;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMD,
    ST_OUT
  } fta_state_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        done;   // slot taken (lock) or entry freed (unlock)
    logic        any;    // a surviving lock has been seen
    logic [15:0] best;   // largest surviving lock so far
  } fta_tok_t;

endpackage

`default_nettype wire

@@ rtl/fan_target_lock_arbiter.sv @@
// Fan target lock arbiter: top level with request sequencer and slot chain.
// Depends on fta_pkg and fta_cell.
//
// Usage: one request item per handshake on in_valid/in_ready (in_kind,
// in_target_value); one result item per request on out_valid/out_ready
// (out_current_target, out_target_applied, out_lock_count, out_lock_rejected).
// Items are handled one at a time: in_ready is high only while idle.
// Request handling:
//   set or unknown request: resolved in ST_CMD; the result is registered
//   as the state moves on to ST_OUT.
//   lock or unlock request: a token walks the chain of LOCK_SLOTS cells, one
//   cell a cycle; the result is registered once the token leaves the last cell.
// Reset: target 0, no locks held, no result pending; the block is ready in
// the cycle after reset is released.
// Receiver stall: the result is held in the output registers, unchanged,
// until out_ready; no new request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module fan_target_lock_arbiter #(
  parameter int LOCK_SLOTS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_kind,
  input  wire  [15:0] in_target_value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] out_current_target,
  output logic        out_target_applied,
  output logic [3:0]  out_lock_count,
  output logic        out_lock_rejected
);
  import fta_pkg::*;

  localparam int CW = $clog2(LOCK_SLOTS + 1);

  fta_state_t  state_r, state_nxt;
  logic [1:0]  kind_r;
  logic [15:0] value_r;
  logic [15:0] target_r, target_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        applied_r, applied_nxt;
  logic        rejected_r, rejected_nxt;

  fta_tok_t    tok [LOCK_SLOTS+1];
  fta_tok_t    tok_last;
  logic        in_acc;
  logic        scan_kind;
  logic        fin;

  assign in_acc    = in_valid && in_ready;
  assign scan_kind = in_kind inside {KIND_LOCK, KIND_UNLOCK};
  assign tok_last  = tok[LOCK_SLOTS];

  // token enters the first cell as the request is accepted
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_acc && scan_kind;
    tok[0].kind  = in_kind;
    tok[0].value = in_target_value;
  end

  for (genvar g = 0; g < LOCK_SLOTS; g++) begin : g_cell
    fta_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = scan_kind ? ST_SCAN : ST_CMD;
      ST_SCAN: if (tok_last.valid) state_nxt = ST_OUT;
      ST_CMD:  state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign fin = (state_r == ST_CMD) || ((state_r == ST_SCAN) && tok_last.valid);

  // result and state update once the request has been resolved
  always_comb begin
    target_nxt   = target_r;
    cnt_nxt      = cnt_r;
    applied_nxt  = applied_r;
    rejected_nxt = rejected_r;
    if (fin) begin
      applied_nxt  = 1'b0;
      rejected_nxt = 1'b0;
      case (kind_r)
        KIND_SET: begin
          if ((cnt_r == '0) && (value_r != target_r)) begin
            target_nxt  = value_r;
            applied_nxt = 1'b1;
          end
        end
        KIND_LOCK: begin
          if (tok_last.done) begin
            cnt_nxt = CW'(cnt_r + 1'b1);
            if (((value_r >= target_r) || (cnt_r == '0)) && (value_r != target_r)) begin
              target_nxt  = value_r;
              applied_nxt = 1'b1;
            end
          end else begin
            rejected_nxt = 1'b1;
          end
        end
        KIND_UNLOCK: begin
          if (tok_last.done) begin
            cnt_nxt = CW'(cnt_r - 1'b1);
            if (tok_last.any && (tok_last.best != target_r)) begin
              target_nxt  = tok_last.best;
              applied_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      target_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      target_r <= target_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    applied_r  <= applied_nxt;
    rejected_r <= rejected_nxt;
    if (in_acc) begin
      kind_r  <= in_kind;
      value_r <= in_target_value;
    end
  end

  assign out_current_target = target_r;
  assign out_target_applied = applied_r;
  assign out_lock_count     = 4'(cnt_r);
  assign out_lock_rejected  = rejected_r;

endmodule

`default_nettype wire

@@ rtl/fta_cell.sv @@
// One lock slot of the arbiter: holds a value and its valid bit, and
// updates the scan token on its way to the next slot. Uses fta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fta_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  fta_pkg::fta_tok_t tok_i,
  output fta_pkg::fta_tok_t tok_o
);
  import fta_pkg::*;

  logic [15:0] val_r, val_nxt;
  logic        vld_r, vld_nxt;
  fta_tok_t    tok_r, tok_nxt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      case (tok_i.kind)
        KIND_LOCK: begin
          // first free slot takes the lock
          if (!vld_r && !tok_i.done) begin
            val_nxt      = tok_i.value;
            vld_nxt      = 1'b1;
            tok_nxt.done = 1'b1;
          end
        end
        KIND_UNLOCK: begin
          // first matching slot is freed; the rest feed the running maximum
          if (vld_r && !tok_i.done && (val_r == tok_i.value)) begin
            vld_nxt      = 1'b0;
            tok_nxt.done = 1'b1;
          end else if (vld_r && (!tok_i.any || (val_r > tok_i.best))) begin
            tok_nxt.any  = 1'b1;
            tok_nxt.best = val_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

@@ rtl/fta_checker.sv @@
// Port-level checks for the fan target lock arbiter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module fta_checker #(
  parameter int LOCK_SLOTS = 8
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_current_target,
  input wire        out_target_applied,
  input wire [3:0]  out_lock_count,
  input wire        out_lock_rejected
);

  // one item in flight: no request taken while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an item was accepted");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((LOCK_SLOTS > 15) || (out_lock_count <= LOCK_SLOTS)))
    else $error("lock count beyond the number of slots");

  a_reject_no_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lock_rejected) |-> !out_target_applied)
    else $error("dropped lock reported a new target");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_current_target)))
    else $error("stalled result changed");

endmodule

bind fan_target_lock_arbiter fta_checker #(.LOCK_SLOTS(LOCK_SLOTS)) u_fta_checker (.*);

`default_nettype wire

@@ sim/fan_target_lock_arbiter_tb.sv @@
// Self-checking testbench for fan_target_lock_arbiter: directed table, then random requests.
// Depends on fta_pkg and the block's RTL; checks results against typed rows or an in-bench predictor.
`timescale 1ns / 1ps

module fan_target_lock_arbiter_tb;
  import fta_pkg::*;

  localparam int LOCK_SLOTS = 8;
  localparam int RANDOM_PER_PHASE = 300;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unknown request, does nothing

  typedef struct packed {
    logic [15:0] target;
    logic        applied;
    logic [3:0]  count;
    logic        rejected;
  } lock_result_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [15:0]  value;
    logic         typed;   // want holds a hand-written result
    lock_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_SET;
  logic [15:0] in_target_value = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_current_target;
  logic        out_target_applied;
  logic [3:0]  out_lock_count;
  logic        out_lock_rejected;

  // predicted block state
  logic [15:0] fan_target;
  logic [15:0] slot_value [LOCK_SLOTS];
  logic        slot_held [LOCK_SLOTS];

  lock_result_t expected_results [$];
  lock_result_t oldest_expected;
  stim_row_t    directed_rows [24];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int locks_taken = 0;
  int locks_dropped = 0;
  int unlocks_matched = 0;
  int target_writes = 0;

  fan_target_lock_arbiter #(
    .LOCK_SLOTS(LOCK_SLOTS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_target_value   (in_target_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_target(out_current_target),
    .out_target_applied(out_target_applied),
    .out_lock_count    (out_lock_count),
    .out_lock_rejected (out_lock_rejected)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("[fan_target_lock_arbiter] ERROR");
    $finish;
  end

  // Works out the result of one request and advances the predicted state.
  function automatic lock_result_t predict_request(logic [1:0] kind, logic [15:0] value);
    lock_result_t res;
    int held;
    int slot;
    logic found;
    logic [15:0] top;
    res = '0;
    held = 0;
    slot = -1;
    found = 1'b0;
    top = 16'h0000;
    for (int i = 0; i < LOCK_SLOTS; i++) if (slot_held[i]) held++;
    case (kind)
      KIND_SET: begin
        if (held == 0 && value != fan_target) begin
          fan_target = value;
          res.applied = 1'b1;
        end
      end
      KIND_LOCK: begin
        for (int i = 0; i < LOCK_SLOTS; i++) if (!slot_held[i] && slot < 0) slot = i;
        if (slot < 0) begin
          res.rejected = 1'b1;
          locks_dropped++;
        end else begin
          // first lock may lower the target, later ones only raise it
          if ((value >= fan_target || held == 0) && value != fan_target) begin
            fan_target = value;
            res.applied = 1'b1;
          end
          slot_value[slot] = value;
          slot_held[slot] = 1'b1;
          locks_taken++;
        end
      end
      KIND_UNLOCK: begin
        for (int i = 0; i < LOCK_SLOTS; i++)
          if (slot_held[i] && slot_value[i] == value && slot < 0) slot = i;
        if (slot >= 0) begin
          slot_held[slot] = 1'b0;
          unlocks_matched++;
          for (int i = 0; i < LOCK_SLOTS; i++) begin
            if (slot_held[i] && (!found || slot_value[i] > top)) begin
              top = slot_value[i];
              found = 1'b1;
            end
          end
          if (found && top != fan_target) begin
            fan_target = top;
            res.applied = 1'b1;
          end
        end
      end
      default: ;
    endcase
    held = 0;
    for (int i = 0; i < LOCK_SLOTS; i++) if (slot_held[i]) held++;
    res.target = fan_target;
    res.count = 4'(held);
    if (res.applied) target_writes++;
    return res;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return fan_target + 16'($urandom_range(0, 2)) - 16'd1;
    endcase
  endfunction

  function automatic logic [15:0] pick_held_value();
    int picks [$];
    for (int i = 0; i < LOCK_SLOTS; i++) if (slot_held[i]) picks.insert(picks.size(), i);
    if (picks.size() == 0) return pick_value();
    return slot_value[picks[$urandom_range(0, picks.size() - 1)]];
  endfunction

  // Presents one request and waits for the handshake; valid stays up if no gap follows.
  task automatic send_request(logic [1:0] kind, logic [15:0] value, logic typed,
                              lock_result_t want);
    lock_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_target_value <= value;
    do @(posedge clk); while (!in_ready);
    predicted = predict_request(kind, value);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
    requests_sent++;
  endtask

  // Holds the sender off until every outstanding result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, got target %h count %0d",
                 $time, out_current_target, out_lock_count);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("current_target", oldest_expected.target, out_current_target);
        check_field("target_applied", 16'(oldest_expected.applied), 16'(out_target_applied));
        check_field("lock_count", 16'(oldest_expected.count), 16'(out_lock_count));
        check_field("lock_rejected", 16'(oldest_expected.rejected), 16'(out_lock_rejected));
        results_checked++;
      end
    end
  end

  initial begin
    logic [1:0]  rnd_kind;
    logic [15:0] rnd_value;
    int          roll;

    fan_target = 16'h0000;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      slot_value[i] = 16'h0000;
      slot_held[i] = 1'b0;
    end

    directed_rows = '{
      '{KIND_SET,    16'h0000, 1'b1, '{16'h0000, 1'b0, 4'd0, 1'b0}},
      '{KIND_SET,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 4'd0, 1'b0}},
      '{KIND_SET,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 4'd0, 1'b0}},
      '{KIND_NONE,   16'h1234, 1'b1, '{16'hFFFF, 1'b0, 4'd0, 1'b0}},
      '{KIND_UNLOCK, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 4'd0, 1'b0}},
      // first lock may lower the target
      '{KIND_LOCK,   16'h0010, 1'b1, '{16'h0010, 1'b1, 4'd1, 1'b0}},
      '{KIND_SET,    16'h5555, 1'b1, '{16'h0010, 1'b0, 4'd1, 1'b0}},
      '{KIND_LOCK,   16'h0008, 1'b0, '0},
      '{KIND_LOCK,   16'h0010, 1'b0, '0},
      '{KIND_LOCK,   16'hFFFF, 1'b0, '0},
      '{KIND_LOCK,   16'h0000, 1'b0, '0},
      '{KIND_LOCK,   16'h0010, 1'b0, '0},
      '{KIND_LOCK,   16'h8000, 1'b0, '0},
      '{KIND_LOCK,   16'h0001, 1'b0, '0},
      // table now full
      '{KIND_LOCK,   16'h2222, 1'b1, '{16'hFFFF, 1'b0, 4'd8, 1'b1}},
      '{KIND_UNLOCK, 16'h3333, 1'b0, '0},
      '{KIND_UNLOCK, 16'h0010, 1'b0, '0},
      '{KIND_LOCK,   16'h7777, 1'b0, '0},
      '{KIND_UNLOCK, 16'hFFFF, 1'b0, '0},
      '{KIND_LOCK,   16'h8000, 1'b0, '0},
      // remaining maximum equals the target: no write
      '{KIND_UNLOCK, 16'h8000, 1'b0, '0},
      '{KIND_NONE,   16'hFFFF, 1'b0, '0},
      '{KIND_SET,    16'h0000, 1'b0, '0},
      '{KIND_UNLOCK, 16'h0000, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 13 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        // locks and matching unlocks balance, so the table walks between empty and full
        if (roll < 32) begin
          rnd_kind = KIND_LOCK;
          rnd_value = pick_value();
        end else if (roll < 62) begin
          rnd_kind = KIND_UNLOCK;
          rnd_value = pick_held_value();
        end else if (roll < 82) begin
          rnd_kind = KIND_SET;
          rnd_value = pick_value();
        end else if (roll < 92) begin
          rnd_kind = KIND_UNLOCK;
          rnd_value = pick_value();
        end else begin
          rnd_kind = KIND_NONE;
          rnd_value = 16'($urandom);
        end
        send_request(rnd_kind, rnd_value, 1'b0, '0);
      end
    end

    drain_results();
    repeat (4 * LOCK_SLOTS) @(posedge clk);

    $display("Checked %0d results from %0d requests under three handshake idling mixes.",
             results_checked, requests_sent);
    $display("Locks held %0d, dropped when full %0d, unlocks matched %0d, target writes %0d.",
             locks_taken, locks_dropped, unlocks_matched, target_writes);
    if (mismatch_count == 0) begin
      $display("[fan_target_lock_arbiter] OK");
    end else begin
      $display("[fan_target_lock_arbiter] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fta_pkg.sv
rtl/fta_cell.sv
rtl/fan_target_lock_arbiter.sv
rtl/fta_checker.sv
sim/fan_target_lock_arbiter_tb.sv
